@@ sv/nta_pkg.sv @@
// Shared types and constants for the neighbor table with aging.
package nta_pkg;

    localparam int IFC_W  = 2;
    localparam int RID_W  = 32;
    localparam int ADDR_W = 32;
    localparam int AGE_W  = 8;
    localparam int TOT_W  = 5;
    // wide enough to count a table of up to 127 entries
    localparam int CNT_W  = 7;

    localparam logic [AGE_W-1:0] DEAD_LIMIT_RST = 8'd15;
    localparam logic [AGE_W-1:0] AGE_MAX        = 8'hFF;

    localparam logic FUNC_HELLO = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // request walking down the chain of entry cells
    typedef struct packed {
        logic               valid;
        logic               tick;
        logic [IFC_W-1:0]   iface;
        logic [RID_W-1:0]   rid;
        logic               match;
        logic               free_seen;
        logic               removed;
        logic [CNT_W-1:0]   cnt;
    } t_tok;

    // end-of-walk command broadcast to every cell
    typedef struct packed {
        logic               clr;
        logic               ins;
        logic [IFC_W-1:0]   iface;
        logic [RID_W-1:0]   rid;
        logic [ADDR_W-1:0]  ip;
        logic [ADDR_W-1:0]  mask;
    } t_cmt;

endpackage

@@ sv/neighbor_table_with_aging.sv @@
// Top level: request control, dead-limit register and the chain of entry cells.
// A hello or tick walks the chain one cell per cycle, through the launch register and each
//   cell's token register, and its result is then registered for the response. A hello
//   on an unknown interface can be taken in the cycle after acceptance.
// Only one item is in flight at a time; the next is taken in the cycle after the result
//   is taken.
// Reset (synchronous, active low) empties the table and sets dead_limit to 15.
module neighbor_table_with_aging #(
    parameter int TABLE_ENTRIES = 16,
    parameter int NUM_IFACES    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [nta_pkg::IFC_W-1:0]   i_iface_index,
    input  logic [nta_pkg::RID_W-1:0]   i_neighbor_rid,
    input  logic [nta_pkg::ADDR_W-1:0]  i_neighbor_ip,
    input  logic [nta_pkg::ADDR_W-1:0]  i_neighbor_mask,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_topology_changed,
    output logic                        o_added_new,
    output logic                        o_table_full,
    output logic [nta_pkg::TOT_W-1:0]   o_total_neighbors,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [nta_pkg::AGE_W-1:0]   i_cfg_dead_limit
);
    import nta_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RESP
    } t_state;

    t_state            r_state;
    logic [AGE_W-1:0]  r_dead_limit;
    t_tok              r_launch;
    logic [IFC_W-1:0]  r_iface;
    logic [RID_W-1:0]  r_rid;
    logic [ADDR_W-1:0] r_ip;
    logic [ADDR_W-1:0] r_mask;
    logic [CNT_W-1:0]  r_count;
    logic              r_changed;
    logic              r_added;
    logic              r_full;
    logic [TOT_W-1:0]  r_total;

    t_tok              w_tok [TABLE_ENTRIES+1];
    t_tok              w_last;
    t_cmt              w_cmt;
    logic              w_fin;
    logic              w_ins;
    logic              w_in_range;
    logic [CNT_W-1:0]  n_count;

    assign w_tok[0]   = r_launch;
    assign w_last     = w_tok[TABLE_ENTRIES];
    assign w_fin      = (r_state == S_WALK) && w_last.valid;
    assign w_ins      = w_fin && (w_last.tick == FUNC_HELLO) && !w_last.match
                        && w_last.free_seen;
    assign w_in_range = int'(i_iface_index) < NUM_IFACES;
    assign n_count    = w_last.cnt + CNT_W'(w_ins);

    always_comb begin
        w_cmt.clr   = w_fin && (w_last.tick == FUNC_HELLO);
        w_cmt.ins   = w_ins;
        w_cmt.iface = r_iface;
        w_cmt.rid   = r_rid;
        w_cmt.ip    = r_ip;
        w_cmt.mask  = r_mask;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            nta_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_tok        (w_tok[gi]),
                .i_cmt        (w_cmt),
                .i_dead_limit (r_dead_limit),
                .o_tok        (w_tok[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_dead_limit   <= DEAD_LIMIT_RST;
            r_launch.valid <= 1'b0;
            r_count        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_dead_limit <= i_cfg_dead_limit;
            end
            r_launch.valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_iface <= i_iface_index;
                        r_rid   <= i_neighbor_rid;
                        r_ip    <= i_neighbor_ip;
                        r_mask  <= i_neighbor_mask;
                        if (i_func == FUNC_TICK || w_in_range) begin
                            r_launch.valid     <= 1'b1;
                            r_launch.tick      <= i_func;
                            r_launch.iface     <= i_iface_index;
                            r_launch.rid       <= i_neighbor_rid;
                            r_launch.match     <= 1'b0;
                            r_launch.free_seen <= 1'b0;
                            r_launch.removed   <= 1'b0;
                            r_launch.cnt       <= '0;
                            r_state            <= S_WALK;
                        end else begin
                            // unknown interface: answer at once, table untouched
                            r_changed <= 1'b0;
                            r_added   <= 1'b0;
                            r_full    <= 1'b0;
                            r_total   <= r_count[TOT_W-1:0];
                            r_state   <= S_RESP;
                        end
                    end
                end
                S_WALK: begin
                    if (w_last.valid) begin
                        r_changed <= (w_last.tick == FUNC_TICK) && w_last.removed;
                        r_added   <= w_ins;
                        r_full    <= (w_last.tick == FUNC_HELLO) && !w_last.match
                                     && !w_last.free_seen;
                        r_count   <= n_count;
                        r_total   <= n_count[TOT_W-1:0];
                        r_state   <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = (r_state == S_RESP);
    assign o_topology_changed = r_changed;
    assign o_added_new        = r_added;
    assign o_table_full       = r_full;
    assign o_total_neighbors  = r_total;
    assign o_cfg_ready        = 1'b1;

endmodule

@@ sv/nta_cell.sv @@
// One neighbor table entry; updates itself as a request passes and hands it on.
module nta_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nta_pkg::t_tok              i_tok,
    input  nta_pkg::t_cmt              i_cmt,
    input  logic [nta_pkg::AGE_W-1:0]  i_dead_limit,
    output nta_pkg::t_tok              o_tok
);
    import nta_pkg::*;

    logic              r_valid, n_valid;
    logic              r_cand, n_cand;
    logic [IFC_W-1:0]  r_iface;
    logic [RID_W-1:0]  r_rid;
    logic [ADDR_W-1:0] r_ip;
    logic [ADDR_W-1:0] r_mask;
    logic [AGE_W-1:0]  r_age, n_age;
    t_tok              r_tok, n_tok;
    logic              w_hit;
    logic              w_expire;
    logic              w_write;

    assign w_hit    = r_valid && (r_iface == i_tok.iface) && (r_rid == i_tok.rid);
    assign w_expire = r_valid && (r_age > i_dead_limit);
    // the first free cell seen by the walk takes the new neighbor at the end
    assign w_write  = i_cmt.ins && r_cand;

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        n_age   = r_age;
        n_cand  = r_cand;
        if (i_tok.valid) begin
            if (i_tok.tick == FUNC_TICK) begin
                if (w_expire) begin
                    n_valid       = 1'b0;
                    n_tok.removed = 1'b1;
                end else if (r_valid && r_age != AGE_MAX) begin
                    n_age = r_age + AGE_W'(1);
                end
            end else begin
                if (w_hit) begin
                    n_age       = '0;
                    n_tok.match = 1'b1;
                end
                if (!r_valid && !i_tok.free_seen) begin
                    n_cand = 1'b1;
                end
                if (!r_valid) begin
                    n_tok.free_seen = 1'b1;
                end
            end
            n_tok.cnt = i_tok.cnt + CNT_W'(n_valid);
        end
        if (i_cmt.clr) begin
            n_cand = 1'b0;
        end
        if (w_write) begin
            n_valid = 1'b1;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_cand      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_cand  <= n_cand;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_age <= n_age;
        if (w_write) begin
            r_iface <= i_cmt.iface;
            r_rid   <= i_cmt.rid;
            r_ip    <= i_cmt.ip;
            r_mask  <= i_cmt.mask;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ sv/nta_checker.sv @@
// Port-level checks for the neighbor table, bound to the top level.
module nta_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_topology_changed,
    input logic                        o_added_new,
    input logic                        o_table_full,
    input logic [nta_pkg::TOT_W-1:0]   o_total_neighbors
);
    import nta_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_topology_changed)
        && $stable(o_added_new) && $stable(o_table_full) && $stable(o_total_neighbors))
        else $error("stalled result changed");

    // one request at a time
    a_one_at_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    a_flag_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_added_new && o_table_full)
        && !(o_topology_changed && (o_added_new || o_table_full)))
        else $error("tick and hello flags mixed");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (TABLE_ENTRIES >= 32) || (int'(o_total_neighbors) <= TABLE_ENTRIES))
        else $error("neighbor count above table size");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_added_new |-> (TABLE_ENTRIES >= 32) || (o_total_neighbors != '0))
        else $error("insert with empty table");

endmodule

bind neighbor_table_with_aging nta_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_nta_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_topology_changed (o_topology_changed),
    .o_added_new        (o_added_new),
    .o_table_full       (o_table_full),
    .o_total_neighbors  (o_total_neighbors)
);
